>>> rtl/ffsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

    localparam int POOL_UNITS_DEF   = 1024;
    localparam int MAX_SEGMENTS_DEF = 16;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_COMPACT = 2'd2;
    localparam logic [1:0] CMD_STATUS  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam int IN_BYTES  = 5;
    localparam int OUT_BYTES = 7;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_SET   = 2'd1,
        OP_SPLIT = 2'd2,
        OP_MERGE = 2'd3
    } t_cell_op;

endpackage
`default_nettype wire

>>> rtl/first_fit_segment_allocator.sv
// sequence: a transaction runs through a scan (allocate or free) or a pack (compact), then
// a summary sweep over the table and one output load; status and bad sizes skip the scan
// throughput: one transaction at a time, the next input is taken in the cycle after the
// result load; a waiting result holds the output load
// reset: synchronous active low; the table returns to one free segment over the whole pool
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator #(
    parameter int POOL_UNITS   = ffsa_pkg::POOL_UNITS_DEF,
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // cmd[1:0], owner_id[17:2], req_size[33:18]
    input  wire  [ffsa_pkg::IN_BYTES*8-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // status[2:0], block_start[12:3], block_size[23:13], free_units[34:24],
    // used_units[45:35], fragment_count[49:46]
    output logic [ffsa_pkg::OUT_BYTES*8-1:0] o_m_tdata
);
    import ffsa_pkg::*;

    localparam int SW = $clog2(POOL_UNITS);
    localparam int LW = $clog2(POOL_UNITS + 1);
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = SW + LW + 17;
    localparam logic [LW-1:0] POOL_L = LW'(POOL_UNITS);
    localparam logic [16:0]   POOL_W = 17'(POOL_UNITS);
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_SEGMENTS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FIND = 5'b00010,
        S_PACK = 5'b00100,
        S_SUM  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_total, n_total;
    logic [1:0]    r_cmd;
    logic [15:0]   r_owner;
    logic [15:0]   r_size;
    logic [2:0]    r_status, n_status;
    logic [SW-1:0] r_bs, n_bs;
    logic [LW-1:0] r_bz, n_bz;
    logic [CW-1:0] r_n, n_n;
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_free, n_free;
    logic [LW-1:0] r_used, n_used;
    logic [CW-1:0] r_frag, n_frag;
    logic          r_prev, n_prev;
    logic          r_out_valid;
    logic [OUT_BYTES*8-1:0] r_out_data;

    logic [EW-1:0] w_ent [MAX_SEGMENTS];
    t_cell_op      w_op;
    logic [CW-1:0] w_pos;
    logic [EW-1:0] w_a, w_b;

    logic [EW-1:0] w_cur, w_nxt;
    logic [SW-1:0] cur_start;
    logic [LW-1:0] cur_len, nxt_len;
    logic [15:0]   cur_owner;
    logic          cur_used, nxt_used;
    logic [CW-1:0] w_idx1;
    logic          w_at_end, w_has_nxt;
    logic          w_in_acc, w_out_load;
    logic [1:0]    in_cmd;
    logic [15:0]   in_owner, in_size;

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
            localparam logic [EW-1:0] RV = (g == 0) ? {1'b0, 16'd0, POOL_L, SW'(0)} : '0;
            ffsa_cell #(.IDX(g), .EW(EW), .CW(CW), .RST_VAL(RV)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (w_op),
                .i_pos   (w_pos),
                .i_a     (w_a),
                .i_b     (w_b),
                .i_left  (w_ent[(g == 0) ? 0 : g-1]),
                .i_right (w_ent[(g == MAX_SEGMENTS-1) ? g : g+1]),
                .o_entry (w_ent[g])
            );
        end
    endgenerate

    assign in_cmd   = i_s_tdata[1:0];
    assign in_owner = i_s_tdata[17:2];
    assign in_size  = i_s_tdata[33:18];

    assign w_idx1    = r_idx + 1'b1;
    assign w_cur     = w_ent[r_idx[IW-1:0]];
    assign w_nxt     = w_ent[w_idx1[IW-1:0]];
    assign cur_start = w_cur[SW-1:0];
    assign cur_len   = w_cur[SW+LW-1:SW];
    assign cur_owner = w_cur[SW+LW+15:SW+LW];
    assign cur_used  = w_cur[EW-1];
    assign nxt_len   = w_nxt[SW+LW-1:SW];
    assign nxt_used  = w_nxt[EW-1];
    assign w_at_end  = (r_idx == r_total);
    assign w_has_nxt = (w_idx1 < r_total);

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_total  = r_total;
        n_status = r_status;
        n_bs     = r_bs;
        n_bz     = r_bz;
        n_n      = r_n;
        n_pos    = r_pos;
        n_free   = r_free;
        n_used   = r_used;
        n_frag   = r_frag;
        n_prev   = r_prev;
        w_op     = OP_HOLD;
        w_pos    = r_idx;
        w_a      = w_cur;
        w_b      = '0;
        unique case (r_state)
            S_IDLE: begin
                n_idx    = '0;
                n_status = ST_OK;
                n_bs     = '0;
                n_bz     = '0;
                n_n      = '0;
                n_pos    = '0;
                n_free   = '0;
                n_used   = '0;
                n_frag   = '0;
                if (w_in_acc) begin
                    unique case (in_cmd)
                        CMD_ALLOC: begin
                            if (in_size == 16'd0 || {1'b0, in_size} > POOL_W) begin
                                n_status = ST_BAD_SIZE;
                                n_state  = S_SUM;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        CMD_FREE:    n_state = S_FIND;
                        CMD_COMPACT: n_state = S_PACK;
                        CMD_STATUS:  n_state = S_SUM;
                        default:     n_state = S_SUM;
                    endcase
                end
            end
            S_FIND: begin
                if (w_at_end) begin
                    n_status = (r_cmd == CMD_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
                    n_state  = S_SUM;
                    n_idx    = '0;
                end else if (r_cmd == CMD_ALLOC) begin
                    if (!cur_used && 17'(cur_len) >= {1'b0, r_size}) begin
                        n_state = S_SUM;
                        n_idx   = '0;
                        if (17'(cur_len) > {1'b0, r_size} && r_total >= MAX_C) begin
                            n_status = ST_FULL;
                        end else begin
                            w_a  = {1'b1, r_owner, LW'(r_size), cur_start};
                            n_bs = cur_start;
                            n_bz = LW'(r_size);
                            if (17'(cur_len) > {1'b0, r_size}) begin
                                w_op    = OP_SPLIT;
                                w_b     = {1'b0, 16'd0, cur_len - LW'(r_size),
                                           cur_start + SW'(r_size)};
                                n_total = r_total + 1'b1;
                            end else begin
                                w_op = OP_SET;
                            end
                        end
                    end else begin
                        n_idx = w_idx1;
                    end
                end else begin
                    if (cur_used && cur_owner == r_owner) begin
                        n_state = S_SUM;
                        n_idx   = '0;
                        n_bs    = cur_start;
                        n_bz    = cur_len;
                        if (w_has_nxt && !nxt_used) begin
                            w_op    = OP_MERGE;
                            w_a     = {1'b0, 16'd0, cur_len + nxt_len, cur_start};
                            n_total = r_total - 1'b1;
                        end else begin
                            w_op = OP_SET;
                            w_a  = {1'b0, 16'd0, cur_len, cur_start};
                        end
                    end else begin
                        n_idx = w_idx1;
                    end
                end
            end
            S_PACK: begin
                w_pos = r_n;
                if (w_at_end) begin
                    n_state = S_SUM;
                    n_idx   = '0;
                    if (r_pos < POOL_L && r_n < MAX_C) begin
                        w_op    = OP_SET;
                        w_a     = {1'b0, 16'd0, POOL_L - r_pos, SW'(r_pos)};
                        n_total = r_n + 1'b1;
                    end else begin
                        n_total = r_n;
                    end
                end else begin
                    n_idx = w_idx1;
                    if (cur_used) begin
                        w_op  = OP_SET;
                        w_a   = {1'b1, cur_owner, cur_len, SW'(r_pos)};
                        n_n   = r_n + 1'b1;
                        n_pos = r_pos + cur_len;
                    end
                end
            end
            S_SUM: begin
                if (w_at_end) begin
                    n_state = S_DONE;
                end else begin
                    n_idx  = w_idx1;
                    n_prev = cur_used;
                    if (cur_used) n_used = r_used + cur_len;
                    else n_free = r_free + cur_len;
                    if (r_idx != '0 && cur_used != r_prev) n_frag = r_frag + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= CW'(1);
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_idx   <= n_idx;
            if (w_out_load) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd   <= in_cmd;
            r_owner <= in_owner;
            r_size  <= in_size;
        end
        r_status <= n_status;
        r_bs     <= n_bs;
        r_bz     <= n_bz;
        r_n      <= n_n;
        r_pos    <= n_pos;
        r_free   <= n_free;
        r_used   <= n_used;
        r_frag   <= n_frag;
        r_prev   <= n_prev;
        if (w_out_load) begin
            r_out_data <= {6'd0, 4'(r_frag), 11'(r_used), 11'(r_free), 11'(r_bz),
                           10'(r_bs), r_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != '0) && (r_total <= MAX_C))
        else $error("segment count out of range");

    a_pool_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((LW+1)'(r_free) + (LW+1)'(r_used) == (LW+1)'(POOL_UNITS)))
        else $error("free and used units do not cover the pool");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_state == S_IDLE) && o_m_tvalid)
        else $error("result load did not return to idle");

endmodule
`default_nettype wire

>>> rtl/ffsa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ffsa_cell #(
    parameter int          IDX     = 0,
    parameter int          EW      = 38,
    parameter int          CW      = 5,
    parameter logic [EW-1:0] RST_VAL = '0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ffsa_pkg::t_cell_op   i_op,
    input  wire  [CW-1:0]        i_pos,
    input  wire  [EW-1:0]        i_a,
    input  wire  [EW-1:0]        i_b,
    input  wire  [EW-1:0]        i_left,
    input  wire  [EW-1:0]        i_right,
    output logic [EW-1:0]        o_entry
);
    import ffsa_pkg::*;

    localparam logic [CW:0] ME = (CW+1)'(IDX);

    logic [EW-1:0] r_ent;
    logic [EW-1:0] n_ent;
    logic [CW:0]   w_pos;
    logic [CW:0]   w_pos1;

    assign w_pos  = {1'b0, i_pos};
    assign w_pos1 = w_pos + 1'b1;

    always_comb begin
        n_ent = r_ent;
        unique case (i_op)
            OP_HOLD: n_ent = r_ent;
            OP_SET: begin
                if (ME == w_pos) n_ent = i_a;
            end
            OP_SPLIT: begin
                priority if (ME == w_pos) n_ent = i_a;
                else if (ME == w_pos1) n_ent = i_b;
                else if (ME > w_pos1) n_ent = i_left;
            end
            OP_MERGE: begin
                priority if (ME == w_pos) n_ent = i_a;
                else if (ME > w_pos) n_ent = i_right;
            end
            default: n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= RST_VAL;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_entry = r_ent;

endmodule
`default_nettype wire

>>> tb/sv/ffsa_checker.sv
`timescale 1ns / 1ps
module ffsa_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    input  wire        i_s_tready,
    input  wire [39:0] i_s_tdata,
    input  wire        i_m_tvalid,
    input  wire        i_m_tready,
    input  wire [55:0] i_m_tdata,
    output int         o_errors,
    output int         o_pending
);
    import ffsa_pkg::*;

    localparam int POOL = POOL_UNITS_DEF;
    localparam int NSEG = MAX_SEGMENTS_DEF;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  bstart;
        logic [10:0] bsize;
        logic [10:0] free_u;
        logic [10:0] used_u;
        logic [3:0]  frags;
    } t_result;

    int unsigned seg_start [NSEG];
    int unsigned seg_len [NSEG];
    int unsigned seg_owner [NSEG];
    bit          seg_used [NSEG];
    int unsigned seg_count;
    t_result     expected_results[$];

    function automatic void table_reset();
        for (int i = 0; i < NSEG; i++) begin
            seg_start[i] = 0;
            seg_len[i] = 0;
            seg_owner[i] = 0;
            seg_used[i] = 0;
        end
        seg_len[0] = POOL;
        seg_count = 1;
    endfunction

    function automatic t_result predict_allocator(logic [1:0] cmd, int unsigned owner,
                                                  int unsigned size);
        t_result r;
        int unsigned n, pos;
        bit done;
        r = '0;
        done = 0;
        if (cmd == CMD_ALLOC) begin
            if (size == 0 || size > POOL) begin
                r.status = ST_BAD_SIZE;
            end else begin
                r.status = ST_NO_FIT;
                for (int i = 0; i < seg_count && !done; i++) begin
                    if (!seg_used[i] && seg_len[i] >= size) begin
                        done = 1;
                        if (seg_len[i] > size && seg_count >= NSEG) begin
                            r.status = ST_FULL;
                        end else begin
                            if (seg_len[i] > size) begin
                                for (int j = seg_count; j > i + 1; j--) begin
                                    seg_start[j] = seg_start[j-1];
                                    seg_len[j] = seg_len[j-1];
                                    seg_owner[j] = seg_owner[j-1];
                                    seg_used[j] = seg_used[j-1];
                                end
                                seg_start[i+1] = seg_start[i] + size;
                                seg_len[i+1] = seg_len[i] - size;
                                seg_owner[i+1] = 0;
                                seg_used[i+1] = 0;
                                seg_count++;
                            end
                            seg_len[i] = size;
                            seg_owner[i] = owner;
                            seg_used[i] = 1;
                            r.status = ST_OK;
                            r.bstart = 10'(seg_start[i]);
                            r.bsize = 11'(size);
                        end
                    end
                end
            end
        end else if (cmd == CMD_FREE) begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < seg_count && !done; i++) begin
                if (seg_used[i] && seg_owner[i] == owner) begin
                    done = 1;
                    r.status = ST_OK;
                    r.bstart = 10'(seg_start[i]);
                    r.bsize = 11'(seg_len[i]);
                    seg_used[i] = 0;
                    seg_owner[i] = 0;
                    if (i + 1 < seg_count && !seg_used[i+1]) begin
                        seg_len[i] += seg_len[i+1];
                        for (int j = i + 1; j + 1 < seg_count; j++) begin
                            seg_start[j] = seg_start[j+1];
                            seg_len[j] = seg_len[j+1];
                            seg_owner[j] = seg_owner[j+1];
                            seg_used[j] = seg_used[j+1];
                        end
                        seg_count--;
                    end
                end
            end
        end else if (cmd == CMD_COMPACT) begin
            n = 0;
            pos = 0;
            for (int i = 0; i < seg_count; i++) begin
                if (seg_used[i]) begin
                    seg_start[n] = pos;
                    seg_len[n] = seg_len[i];
                    seg_owner[n] = seg_owner[i];
                    seg_used[n] = 1;
                    pos += seg_len[i];
                    n++;
                end
            end
            if (pos < POOL && n < NSEG) begin
                seg_start[n] = pos;
                seg_len[n] = POOL - pos;
                seg_owner[n] = 0;
                seg_used[n] = 0;
                n++;
            end
            seg_count = n;
        end
        for (int i = 0; i < seg_count; i++) begin
            if (seg_used[i]) r.used_u += 11'(seg_len[i]);
            else r.free_u += 11'(seg_len[i]);
            if (i > 0 && seg_used[i] != seg_used[i-1]) r.frags++;
        end
        return r;
    endfunction

    t_result got, want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            table_reset();
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(predict_allocator(i_s_tdata[1:0],
                    32'(i_s_tdata[17:2]), 32'(i_s_tdata[33:18])));
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[2:0], i_m_tdata[12:3], i_m_tdata[23:13],
                       i_m_tdata[34:24], i_m_tdata[45:35], i_m_tdata[49:46]};
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction");
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) o_errors <= o_errors + 1;
                    if (got.status != want.status)
                        $error("status exp %0d got %0d", want.status, got.status);
                    if (got.bstart != want.bstart)
                        $error("block_start exp %0d got %0d", want.bstart, got.bstart);
                    if (got.bsize != want.bsize)
                        $error("block_size exp %0d got %0d", want.bsize, got.bsize);
                    if (got.free_u != want.free_u)
                        $error("free_units exp %0d got %0d", want.free_u, got.free_u);
                    if (got.used_u != want.used_u)
                        $error("used_units exp %0d got %0d", want.used_u, got.used_u);
                    if (got.frags != want.frags)
                        $error("fragment_count exp %0d got %0d", want.frags, got.frags);
                end
            end
        end
    end

    assign o_pending = expected_results.size();
endmodule

>>> tb/sv/tb_first_fit_segment_allocator.sv
`timescale 1ns / 1ps
module tb_first_fit_segment_allocator;
    import ffsa_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    int          errors, pending;
    int          idle_cycles = 0;
    int          stall_mode = 0;
    int unsigned owners[8] = '{0, 1, 2, 3, 100, 16'h8000, 16'h5555, 16'hFFFF};

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    first_fit_segment_allocator u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    ffsa_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern, switching between modes
    always @(posedge clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_first_fit_segment_allocator NOT OK");
            $finish;
        end
    end

    task automatic send_cmd(logic [1:0] cmd, logic [15:0] owner, logic [15:0] size);
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, size, owner, cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    task automatic send_random();
        int unsigned k;
        logic [15:0] sz;
        k = $urandom_range(0, 99);
        case ($urandom_range(0, 5))
            0: sz = 16'($urandom_range(1, 16));
            1, 2: sz = 16'($urandom_range(1, 128));
            3: sz = 16'($urandom_range(1, 1024));
            4: sz = 16'($urandom_range(1000, 1030));
            default: sz = 16'($urandom);
        endcase
        if (k < 50) send_cmd(CMD_ALLOC, 16'(owners[$urandom_range(0, 7)]), sz);
        else if (k < 82) send_cmd(CMD_FREE, $urandom_range(0, 9) == 0 ? 16'($urandom)
                                  : 16'(owners[$urandom_range(0, 7)]), 16'($urandom));
        else if (k < 92) send_cmd(CMD_COMPACT, 16'($urandom), 16'($urandom));
        else send_cmd(CMD_STATUS, 16'($urandom), 16'($urandom));
    endtask

    initial begin
        int unsigned burst;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_cmd(CMD_STATUS, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_ALLOC, 1, 1025);
        send_cmd(CMD_ALLOC, 1, 16'hFFFF);
        send_cmd(CMD_FREE, 7, 0);
        send_cmd(CMD_ALLOC, 16'hFFFF, 1024);
        send_cmd(CMD_ALLOC, 2, 1);
        send_cmd(CMD_COMPACT, 0, 0);
        send_cmd(CMD_FREE, 16'hFFFF, 0);
        send_cmd(CMD_ALLOC, 0, 1);
        send_cmd(CMD_ALLOC, 3, 2);
        send_cmd(CMD_ALLOC, 4, 3);
        send_cmd(CMD_FREE, 3, 0);
        send_cmd(CMD_FREE, 0, 0);
        send_cmd(CMD_ALLOC, 5, 1);
        for (int i = 0; i < 15; i++) send_cmd(CMD_ALLOC, 16'(10 + i), 1);
        send_cmd(CMD_ALLOC, 9, 900);
        send_cmd(CMD_COMPACT, 0, 0);
        send_cmd(CMD_FREE, 12, 0);
        for (int i = 0; i < 16; i++) send_cmd(CMD_FREE, 16'(i), 0);
        send_cmd(CMD_COMPACT, 0, 0);
        for (int n = 0; n < 1750;) begin
            burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 10);
            for (int b = 0; b < burst; b++) send_random();
            n += burst;
            send_gap();
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0) $display("tb_first_fit_segment_allocator OK");
        else $display("tb_first_fit_segment_allocator NOT OK");
        $finish;
    end
endmodule

>>> sim.f
rtl/ffsa_pkg.sv
rtl/ffsa_cell.sv
rtl/first_fit_segment_allocator.sv
tb/sv/ffsa_checker.sv
tb/sv/tb_first_fit_segment_allocator.sv
